/* rtl/gww_pkg.sv */
// Shared types and constants of the greedy word wrap block.
package gww_pkg;

  localparam int CHAR_W       = 8;
  localparam int CFG_W        = 6;
  localparam int MAX_LINE_DEF = 32;

  localparam logic [CHAR_W-1:0] SPACE_CHAR    = 8'd32;
  localparam logic [CHAR_W-1:0] NUL_CHAR      = 8'd0;
  localparam logic [CFG_W-1:0]  LINE_WIDTH_RST = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_EMPTY_OUT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    WRAP_SPACE,
    WRAP_SPLIT,
    WRAP_HARD
  } wrap_e;

endpackage

/* rtl/gww_if.sv */
// Request channel interfaces: text bytes in, line characters out.
interface gww_in_if;
  import gww_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              text_end;

  modport source (output valid, output char_in, output text_end, input ready);
  modport sink (input valid, input char_in, input text_end, output ready);
endinterface

interface gww_out_if;
  import gww_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              char_valid;
  logic              line_end;
  logic              text_done;

  modport source (output valid, output char_out, output char_valid, output line_end,
                  output text_done, input ready);
  modport sink (input valid, input char_out, input char_valid, input line_end,
                input text_done, output ready);
endinterface

/* rtl/gww_line_buf.sv */
// Line buffer memory: one write port, one read port with registered data.
module gww_line_buf #(
  parameter int Depth = gww_pkg::MAX_LINE_DEF,
  parameter int AW    = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [gww_pkg::CHAR_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [gww_pkg::CHAR_W-1:0] rdata_o
);
  import gww_pkg::*;

  logic [CHAR_W-1:0] mem [Depth];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/greedy_word_wrap.sv */
// Greedy word wrap: buffers text bytes and emits wrapped lines one character per request.
// Timing: a byte that only lands in the buffer is stored as it is taken; a wrap or flush
//   emits each character through a memory read state, then the output register.
// Splitting at a space copies the tail to the line start (a read, then a write state
//   per byte), then the append state stores the new byte; input waits until idle again.
// Reset: fill count, space tracking and width (32) clear at once; buffer contents
//   are not cleared since only entries below the fill count are ever read.
module greedy_word_wrap #(
  parameter int MaxLine = gww_pkg::MAX_LINE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [gww_pkg::CFG_W-1:0] cfg_wdata_i,
  gww_in_if.sink                   text_i,
  gww_out_if.source                line_o
);
  import gww_pkg::*;

  localparam int AW = $clog2(MaxLine);      // buffer index
  localparam int CW = $clog2(MaxLine + 1);  // fill count, holds MaxLine itself

  // Control state
  state_e         state_q, state_d;
  logic [CFG_W-1:0] lw_q;
  logic [CW-1:0]  fill_q, fill_d;
  logic [AW-1:0]  sp_q, sp_d;
  logic           seen_q, seen_d;
  logic           out_valid_q;

  // Per-request working registers
  logic [CHAR_W-1:0] char_q, char_d;
  logic              end_q, end_d;
  wrap_e             kind_q, kind_d;
  logic [CW-1:0]     len_q, len_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              flush_q, flush_d;

  // Output register payload
  logic [CHAR_W-1:0] oc_q, oc_d;
  logic              ov_q, ov_d, ole_q, ole_d, odone_q, odone_d;
  logic              out_load;

  // Memory port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata, mem_rdata;

  logic [CW-1:0] eff_w;
  logic          full, in_acc, out_free, emit_last, shift_last;
  logic [AW-1:0] shift_src;
  logic [CW-1:0] rest;

  gww_line_buf #(.Depth(MaxLine), .AW(AW)) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Width clamp: 0 acts as 1, anything above the buffer size as the buffer size.
  always_comb begin
    if (lw_q == '0) begin
      eff_w = CW'(1);
    end else if ({1'b0, lw_q} > 7'(MaxLine)) begin
      eff_w = CW'(MaxLine);
    end else begin
      eff_w = lw_q[CW-1:0];
    end
  end

  assign full       = fill_q >= eff_w;
  assign in_acc     = text_i.valid && text_i.ready;
  assign out_free   = !out_valid_q || line_o.ready;
  assign emit_last  = (CW'(idx_q) + CW'(1)) == len_q;
  assign shift_src  = sp_q + AW'(1) + idx_q;
  assign shift_last = (CW'(idx_q) + CW'(1)) == fill_q;
  assign rest       = fill_q - CW'(sp_q) - CW'(1);  // tail length after the last space

  assign text_i.ready = (state_q == ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (full) begin
            if (text_i.char_in != SPACE_CHAR && seen_q && sp_q == '0) begin
              state_d = ST_EMPTY_OUT;  // last space is the first character
            end else begin
              state_d = ST_EMIT_RD;
            end
          end else if (text_i.text_end) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_OUT;
      ST_EMIT_OUT, ST_EMPTY_OUT: begin
        if (out_free && (state_q == ST_EMPTY_OUT || emit_last)) begin
          if (flush_q) begin
            state_d = ST_IDLE;
          end else begin
            case (kind_q)
              WRAP_SPACE: state_d = end_q ? ST_FLUSH : ST_IDLE;
              WRAP_SPLIT: state_d = (rest != '0) ? ST_SHIFT_RD : ST_APPEND;
              default:    state_d = ST_APPEND;
            endcase
          end
        end else if (out_free) begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_SHIFT_RD: state_d = ST_SHIFT_WR;
      ST_SHIFT_WR: state_d = shift_last ? ST_APPEND : ST_SHIFT_RD;
      ST_APPEND:   state_d = end_q ? ST_FLUSH : ST_IDLE;
      ST_FLUSH:    state_d = (fill_q == '0) ? ST_EMPTY_OUT : ST_EMIT_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    fill_d    = fill_q;
    sp_d      = sp_q;
    seen_d    = seen_q;
    char_d    = char_q;
    end_d     = end_q;
    kind_d    = kind_q;
    len_d     = len_q;
    idx_d     = idx_q;
    flush_d   = flush_q;
    oc_d      = oc_q;
    ov_d      = ov_q;
    ole_d     = ole_q;
    odone_d   = odone_q;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = fill_q[AW-1:0];
    mem_wdata = char_q;
    mem_raddr = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          char_d  = text_i.char_in;
          end_d   = text_i.text_end;
          idx_d   = '0;
          flush_d = 1'b0;
          if (full) begin
            if (text_i.char_in == SPACE_CHAR) begin
              kind_d = WRAP_SPACE;
              len_d  = fill_q;
            end else if (seen_q) begin
              kind_d = WRAP_SPLIT;
              len_d  = CW'(sp_q);
            end else begin
              kind_d = WRAP_HARD;
              len_d  = fill_q;
            end
          end else begin
            // plain store at the end of the line
            mem_we    = 1'b1;
            mem_wdata = text_i.char_in;
            fill_d    = fill_q + CW'(1);
            if (text_i.char_in == SPACE_CHAR) begin
              sp_d   = fill_q[AW-1:0];
              seen_d = 1'b1;
            end
          end
        end
      end
      ST_EMIT_OUT, ST_EMPTY_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (state_q == ST_EMPTY_OUT) begin
            oc_d    = NUL_CHAR;
            ov_d    = 1'b0;
            ole_d   = 1'b1;
            odone_d = flush_q;
          end else begin
            oc_d    = mem_rdata;
            ov_d    = 1'b1;
            ole_d   = emit_last;
            odone_d = flush_q && emit_last;
          end
          if (state_q == ST_EMPTY_OUT || emit_last) begin
            idx_d = '0;
            if (flush_q || kind_q != WRAP_SPLIT) begin
              fill_d = '0;
              sp_d   = '0;
              seen_d = 1'b0;
            end else begin
              // keep sp_q: the tail copy reads from just past it
              fill_d = rest;
              seen_d = 1'b0;
            end
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      ST_SHIFT_RD: mem_raddr = shift_src;
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = mem_rdata;
        idx_d     = shift_last ? '0 : idx_q + AW'(1);
      end
      ST_APPEND: begin
        // the line now holds only a space-free tail, so the space tracking restarts here
        mem_we = 1'b1;
        fill_d = fill_q + CW'(1);
        if (char_q == SPACE_CHAR) begin
          sp_d   = fill_q[AW-1:0];
          seen_d = 1'b1;
        end else begin
          sp_d   = '0;
          seen_d = 1'b0;
        end
      end
      ST_FLUSH: begin
        flush_d = 1'b1;
        len_d   = fill_q;
        idx_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lw_q        <= LINE_WIDTH_RST;
      fill_q      <= '0;
      sp_q        <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      flush_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      sp_q    <= sp_d;
      seen_q  <= seen_d;
      flush_q <= flush_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        lw_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (line_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    char_q  <= char_d;
    end_q   <= end_d;
    kind_q  <= kind_d;
    len_q   <= len_d;
    oc_q    <= oc_d;
    ov_q    <= ov_d;
    ole_q   <= ole_d;
    odone_q <= odone_d;
  end

  assign line_o.valid      = out_valid_q;
  assign line_o.char_out   = oc_q;
  assign line_o.char_valid = ov_q;
  assign line_o.line_end   = ole_q;
  assign line_o.text_done  = odone_q;

  // Fill count never passes the buffer size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CW'(MaxLine))
    else $error("fill count beyond buffer size");

  // A tracked space always lies inside the buffered line.
  assert property (@(posedge clk_i) disable iff (!rst_ni) seen_q |-> (CW'(sp_q) < fill_q))
    else $error("space position outside the line");

  // The tail copy always reads ahead of where it writes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_SHIFT_RD) |-> (shift_src > idx_q))
    else $error("tail copy source not ahead of destination");

  // No result is produced in the cycle a new byte is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |-> !out_load)
    else $error("output load while accepting a byte");

endmodule

/* bench/greedy_word_wrap_tb.sv */
// Self-checking bench for greedy_word_wrap: directed rows, then randomized word streams.
module greedy_word_wrap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gww_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 9;
  localparam int MAX_LINE     = MAX_LINE_DEF;
  // Longest silent work after the last character: a full tail shift plus the append.
  localparam int DRAIN_CYCLES = 4 * MAX_LINE + 16;
  // Long output back-pressure window, long enough to fill the line and stall the input.
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_ITEMS   = 480;
  localparam int PHASE_ITEMS  = 60;
  // Cap on the run length in clock cycles; the bench fails if it is reached.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam logic [CHAR_W-1:0] LETTER_A = 8'h61;

  // One character of an emitted line, as seen on the output channel.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              valid;
    logic              le;
    logic              done;
  } line_char_t;

  typedef line_char_t [1:0] char_pair_t;

  typedef enum logic {
    ROW_WIDTH,
    ROW_BYTE
  } row_kind_e;

  // A directed row either writes line_width or sends one text byte. Rows with a
  // hand-written result carry it in typed[], all others go through the predictor.
  typedef struct {
    row_kind_e         kind;
    logic [CFG_W-1:0]  wd;
    logic [CHAR_W-1:0] ch;
    logic              last;
    int                n_typed;
    char_pair_t        typed;
  } text_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // Hand-written expectation traveling with the byte on offer.
  int         typed_n;
  char_pair_t typed_res;

  gww_in_if  text_if ();
  gww_out_if line_if ();

  greedy_word_wrap dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .text_i      (text_if),
    .line_o      (line_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Line predictor: its own copy of the line buffer, fill count, last space and width.
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] line_buf [MAX_LINE];
  int unsigned       fill_n = 0;
  int unsigned       space_at = 0;
  bit                space_hit = 1'b0;
  logic [CFG_W-1:0]  line_width_q = LINE_WIDTH_RST;

  // Characters still owed by the block, oldest first.
  line_char_t line_chars_q[$];

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  in_gap_max = 5;
  int  out_stall_max = 5;
  bit  hold_out = 1'b0;

  function automatic line_char_t lc(logic [CHAR_W-1:0] ch, logic v, logic le, logic d);
    line_char_t r;
    r.ch    = ch;
    r.valid = v;
    r.le    = le;
    r.done  = d;
    return r;
  endfunction

  // Queue the first len buffered characters as one line; an empty line is one marker.
  function automatic void queue_line(int unsigned len, logic done);
    if (len == 0) begin
      line_chars_q.push_back(lc(NUL_CHAR, 1'b0, 1'b1, done));
    end else begin
      for (int unsigned i = 0; i < len; i++) begin
        line_chars_q.push_back(lc(line_buf[i], 1'b1, i == len - 1, done && (i == len - 1)));
      end
    end
  endfunction

  function automatic void store_char(logic [CHAR_W-1:0] c);
    if (fill_n < MAX_LINE) begin
      line_buf[fill_n] = c;
      if (c == SPACE_CHAR) begin
        space_at  = fill_n;
        space_hit = 1'b1;
      end
      fill_n++;
    end
  endfunction

  function automatic void wrap_text_byte(logic [CHAR_W-1:0] c, logic last);
    int unsigned w;
    int unsigned tail;
    w = line_width_q;
    if (w < 1) w = 1;
    if (w > MAX_LINE) w = MAX_LINE;

    if (fill_n >= w) begin
      if (c == SPACE_CHAR) begin
        // Full line, the space itself is the break and is dropped.
        queue_line(fill_n, 1'b0);
        fill_n    = 0;
        space_at  = 0;
        space_hit = 1'b0;
      end else if (space_hit) begin
        // Break at the last space; the word after it opens the next line.
        tail = fill_n - space_at - 1;
        queue_line(space_at, 1'b0);
        for (int unsigned i = 0; i < tail; i++) line_buf[i] = line_buf[space_at + 1 + i];
        fill_n    = tail;
        space_at  = 0;
        space_hit = 1'b0;
        store_char(c);
      end else begin
        // No space anywhere: hard break at the width.
        queue_line(fill_n, 1'b0);
        fill_n    = 0;
        space_at  = 0;
        space_hit = 1'b0;
        store_char(c);
      end
    end else begin
      store_char(c);
    end

    if (last) begin
      queue_line(fill_n, 1'b1);
      fill_n    = 0;
      space_at  = 0;
      space_hit = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted byte, checks every accepted character.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    int         base;
    line_char_t got;
    line_char_t want;
    if (text_if.valid === 1'b1 && text_if.ready === 1'b1) begin
      base = line_chars_q.size();
      wrap_text_byte(text_if.char_in, text_if.text_end);
      // A typed row replaces what the predictor queued for this byte.
      if (typed_n != 0) begin
        while (line_chars_q.size() > base) void'(line_chars_q.pop_back());
        for (int i = 0; i < typed_n; i++) line_chars_q.push_back(typed_res[i]);
      end
    end
    if (line_if.valid === 1'b1 && line_if.ready === 1'b1) begin
      got = lc(line_if.char_out, line_if.char_valid, line_if.line_end, line_if.text_done);
      if (line_chars_q.size() == 0) begin
        $error("unexpected character: char_out %0h char_valid %0b line_end %0b text_done %0b",
               got.ch, got.valid, got.le, got.done);
        err_cnt++;
      end else begin
        want = line_chars_q.pop_front();
        if (got.ch !== want.ch) begin
          $error("char_out: expected %0h, got %0h", want.ch, got.ch);
          err_cnt++;
        end
        if (got.valid !== want.valid) begin
          $error("char_valid: expected %0b, got %0b", want.valid, got.valid);
          err_cnt++;
        end
        if (got.le !== want.le) begin
          $error("line_end: expected %0b, got %0b", want.le, got.le);
          err_cnt++;
        end
        if (got.done !== want.done) begin
          $error("text_done: expected %0b, got %0b", want.done, got.done);
          err_cnt++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("greedy_word_wrap test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls per request, plus one long hold on demand.
  // ---------------------------------------------------------------------------
  initial begin : line_sink
    int stall;
    line_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_out) begin
        line_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out = 1'b0;
      end
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        line_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      line_if.ready <= 1'b1;
      @(posedge clk_i);
      while (line_if.valid !== 1'b1 && !hold_out) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers
  // ---------------------------------------------------------------------------

  // Offer one byte after a random gap; valid stays high for back-to-back requests.
  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last,
                           input int n_typed, input char_pair_t typed);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_if.valid    <= 1'b1;
    text_if.char_in  <= c;
    text_if.text_end <= last;
    typed_n          <= n_typed;
    typed_res        <= typed;
    do @(posedge clk_i); while (text_if.ready !== 1'b1);
  endtask

  // Drop valid, let every owed character arrive, then cover silent work (tail shift).
  task automatic wait_idle();
    text_if.valid <= 1'b0;
    do @(posedge clk_i); while (line_chars_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_width(input logic [CFG_W-1:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    line_width_q = w;
  endtask

  function automatic text_row_t width_row(logic [CFG_W-1:0] w);
    text_row_t r;
    r.kind    = ROW_WIDTH;
    r.wd      = w;
    r.ch      = NUL_CHAR;
    r.last    = 1'b0;
    r.n_typed = 0;
    r.typed   = '0;
    return r;
  endfunction

  function automatic text_row_t byte_row(logic [CHAR_W-1:0] c, logic last);
    text_row_t r;
    r.kind    = ROW_BYTE;
    r.wd      = '0;
    r.ch      = c;
    r.last    = last;
    r.n_typed = 0;
    r.typed   = '0;
    return r;
  endfunction

  function automatic text_row_t typed_row(logic [CHAR_W-1:0] c, logic last, int n,
                                          line_char_t r0, line_char_t r1);
    text_row_t r;
    r          = byte_row(c, last);
    r.n_typed  = n;
    r.typed[0] = r0;
    r.typed[1] = r1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : text_source
    text_row_t         rows[$];
    int                eff;
    int                n;
    int                split_at;
    int                word_left;
    int                phase;
    int                rand_sent;
    int                sent_in_phase;
    int                mode;
    bit                noisy;
    logic [CHAR_W-1:0] c;

    text_if.valid    <= 1'b0;
    text_if.char_in  <= NUL_CHAR;
    text_if.text_end <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    typed_n          <= 0;
    typed_res        <= '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset width 32: single-byte texts, byte zero is plain data.
    rows.push_back(typed_row(NUL_CHAR, 1'b1, 1, lc(NUL_CHAR, 1'b1, 1'b1, 1'b1), '0));
    rows.push_back(typed_row(8'hFF, 1'b1, 1, lc(8'hFF, 1'b1, 1'b1, 1'b1), '0));
    rows.push_back(typed_row(SPACE_CHAR, 1'b1, 1, lc(SPACE_CHAR, 1'b1, 1'b1, 1'b1), '0));
    // Width 0 behaves as 1: hard break, then a space on a full line leaves an empty final line.
    rows.push_back(width_row(6'd0));
    rows.push_back(byte_row(8'h61, 1'b0));
    rows.push_back(typed_row(8'h62, 1'b0, 1, lc(8'h61, 1'b1, 1'b1, 1'b0), '0));
    rows.push_back(typed_row(SPACE_CHAR, 1'b1, 2, lc(8'h62, 1'b1, 1'b1, 1'b0),
                             lc(NUL_CHAR, 1'b0, 1'b1, 1'b1)));
    // Width 3, leading space: wrap at position zero gives an empty intermediate line.
    rows.push_back(width_row(6'd3));
    rows.push_back(byte_row(SPACE_CHAR, 1'b0));
    rows.push_back(byte_row(8'h61, 1'b0));
    rows.push_back(byte_row(8'h62, 1'b0));
    rows.push_back(typed_row(8'h63, 1'b0, 1, lc(NUL_CHAR, 1'b0, 1'b1, 1'b0), '0));
    rows.push_back(byte_row(8'h78, 1'b1));
    // Width dropped from 32 to 2 with "ab cd" buffered: leftover line exceeds the width.
    rows.push_back(width_row(6'd32));
    rows.push_back(byte_row(8'h61, 1'b0));
    rows.push_back(byte_row(8'h62, 1'b0));
    rows.push_back(byte_row(SPACE_CHAR, 1'b0));
    rows.push_back(byte_row(8'h63, 1'b0));
    rows.push_back(byte_row(8'h64, 1'b0));
    rows.push_back(width_row(6'd2));
    rows.push_back(byte_row(8'h65, 1'b0));
    rows.push_back(byte_row(8'h66, 1'b0));
    rows.push_back(byte_row(SPACE_CHAR, 1'b1));
    // Width 63 behaves as 32.
    rows.push_back(width_row(6'd63));
    rows.push_back(typed_row(8'h71, 1'b1, 1, lc(8'h71, 1'b1, 1'b1, 1'b1), '0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WIDTH) begin
        wait_idle();
        set_width(rows[i].wd);
      end else begin
        send_byte(rows[i].ch, rows[i].last, rows[i].n_typed, rows[i].typed);
      end
    end

    // Random phases: one width each (a text may change it midway), rotating through the idle patterns.
    phase     = 0;
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      wait_idle();
      case (phase)
        0:       set_width(6'd1);
        1:       set_width(6'd32);
        2:       set_width(6'd0);
        3:       set_width(6'd63);
        4:       set_width(6'd33);
        5:       set_width(6'd2);
        default: set_width(6'($urandom_range(1, MAX_LINE)));
      endcase
      mode          = phase % 4;
      in_gap_max    = (mode == 1 || mode == 3) ? 0 : 5;
      out_stall_max = (mode >= 2) ? 0 : 5;
      // Full-width phase with a back-to-back sender: output held so the input backs up.
      if (phase == 1) hold_out = 1'b1;
      sent_in_phase = 0;

      while (sent_in_phase < PHASE_ITEMS && rand_sent < RAND_ITEMS) begin
        noisy     = ($urandom_range(0, 4) == 0);
        n         = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 48);
        word_left = $urandom_range(0, 3);
        split_at  = ($urandom_range(0, 9) == 0 && n > 1) ? $urandom_range(1, n - 1) : -1;
        for (int i = 0; i < n; i++) begin
          // Width change in the middle of a text, block idle but line partly filled.
          if (i == split_at) begin
            wait_idle();
            set_width(6'($urandom_range(0, 8)));
          end
          eff = (line_width_q == 0) ? 1 : (line_width_q > MAX_LINE) ? MAX_LINE : line_width_q;
          if (noisy && $urandom_range(0, 2) == 0) begin
            c = 8'($urandom_range(0, 255));
          end else if (word_left == 0) begin
            c = SPACE_CHAR;
            if ($urandom_range(0, 7) == 0) word_left = 0;
            else if ($urandom_range(0, 5) == 0) word_left = $urandom_range(1, 40);
            else word_left = $urandom_range(1, eff + 1);
          end else begin
            c = LETTER_A + 8'($urandom_range(0, 25));
            word_left--;
          end
          send_byte(c, i == n - 1, 0, '0);
          rand_sent++;
          sent_in_phase++;
        end
      end
      phase++;
    end

    // Sender pauses here until every owed character is back.
    wait_idle();
    if (err_cnt == 0) begin
      $display("greedy_word_wrap test passed");
    end else begin
      $display("greedy_word_wrap test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/gww_pkg.sv
rtl/gww_if.sv
rtl/gww_line_buf.sv
rtl/greedy_word_wrap.sv
bench/greedy_word_wrap_tb.sv
